@@ src/chc_pkg.sv @@
// shared types, constants and the arctangent table for the compass heading block
package chc_pkg;

  // field widths
  localparam int MAG_W = 16;
  localparam int DEG_W = 9;

  // cordic sizing
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_IDX_W   = 5;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int PRESCALE_SH  = 24;
  localparam int CW           = 43;
  localparam int AW           = 26;
  localparam int DEG_FRAC     = 16;

  // action codes on the sample word
  localparam logic [1:0] ACT_HEADING    = 2'd0;
  localparam logic [1:0] ACT_CAL_START  = 2'd1;
  localparam logic [1:0] ACT_CAL_SAMPLE = 2'd2;
  localparam logic [1:0] ACT_CAL_END    = 2'd3;

  // angle constants in degrees, with 16 fraction bits but for DEG_360
  localparam logic signed [AW-1:0] ACC_P90  = AW'(5898240);
  localparam logic signed [AW-1:0] ACC_N90  = AW'(-5898240);
  localparam logic signed [AW-1:0] ACC_180  = AW'(11796480);
  localparam logic signed [AW-1:0] ACC_360  = AW'(23592960);
  localparam logic [DEG_W-1:0]     DEG_360  = DEG_W'(360);

  typedef enum logic [1:0] {
    OP_HEADING,
    OP_CAL_START,
    OP_CAL_SAMPLE,
    OP_CAL_END
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [MAG_W-1:0] x;
    logic signed [MAG_W-1:0] y;
    logic signed [MAG_W-1:0] z;
  } item_t;

  typedef enum logic [1:0] {
    CD_IDLE,
    CD_ITER,
    CD_FINAL
  } cd_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } bk_state_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded
  function automatic logic signed [AW-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [AW-1:0] r;
    case (idx)
      5'd0:    r = AW'(2949120);
      5'd1:    r = AW'(1740967);
      5'd2:    r = AW'(919879);
      5'd3:    r = AW'(466945);
      5'd4:    r = AW'(234379);
      5'd5:    r = AW'(117304);
      5'd6:    r = AW'(58666);
      5'd7:    r = AW'(29335);
      5'd8:    r = AW'(14668);
      5'd9:    r = AW'(7334);
      5'd10:   r = AW'(3667);
      5'd11:   r = AW'(1833);
      5'd12:   r = AW'(917);
      5'd13:   r = AW'(458);
      5'd14:   r = AW'(229);
      5'd15:   r = AW'(115);
      5'd16:   r = AW'(57);
      5'd17:   r = AW'(29);
      5'd18:   r = AW'(14);
      5'd19:   r = AW'(7);
      5'd20:   r = AW'(4);
      5'd21:   r = AW'(2);
      5'd22:   r = AW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ src/chc_front.sv @@
// front end: takes sample words, decodes the action and queues them two deep
module chc_front import chc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  logic [1:0]              action,
  input  logic signed [MAG_W-1:0] mag_x,
  input  logic signed [MAG_W-1:0] mag_y,
  input  logic signed [MAG_W-1:0] mag_z,
  output logic                    q_valid,
  output item_t                   q_item,
  input  logic                    q_pop
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      item_in;

  // decode the action code into an operation
  always_comb begin
    case (action)
      ACT_HEADING:    item_in.op = OP_HEADING;
      ACT_CAL_START:  item_in.op = OP_CAL_START;
      ACT_CAL_SAMPLE: item_in.op = OP_CAL_SAMPLE;
      ACT_CAL_END:    item_in.op = OP_CAL_END;
      default:        item_in.op = OP_HEADING;
    endcase
    item_in.x = mag_x;
    item_in.y = mag_y;
    item_in.z = mag_z;
  end

  assign sample_ready = (count != 2'd2);
  assign push         = sample_valid && sample_ready;
  assign q_valid      = (count != 2'd0);
  assign q_item       = slot[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= item_in;
  end

endmodule

@@ src/chc_cordic.sv @@
// iterative vectoring cordic: atan2(y, x) in whole degrees 0..359
module chc_cordic import chc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [MAG_W-1:0] mag_x,
  input  logic signed [MAG_W-1:0] mag_y,
  output logic                    done,
  output logic [DEG_W-1:0]        heading
);

  cd_state_t            state;
  cd_state_t            state_next;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [AW-1:0] acc;
  logic [STEP_W-1:0]    step;
  logic                 last_step;

  logic signed [MAG_W:0]  neg_x;
  logic signed [MAG_W:0]  neg_y;
  logic signed [CW-1:0]   xs;
  logic signed [CW-1:0]   ys;
  logic signed [AW-1:0]   ang;
  logic signed [AW-1:0]   acc_adj;
  logic [AW-DEG_FRAC-1:0] deg_wide;
  logic [AW-DEG_FRAC-1:0] deg_fix;

  // widen a 17-bit value and scale it by 2^24
  function automatic logic signed [CW-1:0] prescale(input logic signed [MAG_W:0] v);
    return {{(CW-MAG_W-1-PRESCALE_SH){v[MAG_W]}}, v, {PRESCALE_SH{1'b0}}};
  endfunction

  assign neg_x     = -{mag_x[MAG_W-1], mag_x};
  assign neg_y     = -{mag_y[MAG_W-1], mag_y};
  assign xs        = x >>> step;
  assign ys        = y >>> step;
  assign ang       = atan_q16(ATAN_IDX_W'(step));
  assign last_step = (step == STEP_W'(CORDIC_STEPS - 1));

  // wrap the final angle into 0..359
  assign acc_adj  = acc[AW-1] ? acc + ACC_360 : acc;
  assign deg_wide = acc_adj[AW-1:DEG_FRAC];
  assign deg_fix  = (deg_wide >= (AW-DEG_FRAC)'(360)) ?
                    deg_wide - (AW-DEG_FRAC)'(360) : deg_wide;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      CD_IDLE: begin
        if (start) state_next = (mag_y == '0) ? CD_FINAL : CD_ITER;
      end
      CD_ITER: begin
        if (last_step) state_next = CD_FINAL;
      end
      CD_FINAL: state_next = CD_IDLE;
      default:  state_next = CD_IDLE;
    endcase
  end

  // done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == CD_FINAL);
    end
  end

  // rotation datapath
  always_ff @(posedge clk) begin
    case (state)
      CD_IDLE: begin
        step <= '0;
        if (mag_y == '0) begin
          acc <= mag_x[MAG_W-1] ? ACC_180 : '0;
          x   <= '0;
          y   <= '0;
        end else if (!mag_y[MAG_W-1]) begin
          // rotate by -90 degrees
          x   <= prescale({mag_y[MAG_W-1], mag_y});
          y   <= prescale(neg_x);
          acc <= ACC_P90;
        end else begin
          // rotate by +90 degrees
          x   <= prescale(neg_y);
          y   <= prescale({mag_x[MAG_W-1], mag_x});
          acc <= ACC_N90;
        end
      end
      CD_ITER: begin
        step <= step + 1'b1;
        if (y > 0) begin
          x   <= x + ys;
          y   <= y - xs;
          acc <= acc + ang;
        end else if (y < 0) begin
          x   <= x - ys;
          y   <= y + xs;
          acc <= acc - ang;
        end
      end
      CD_FINAL: heading <= DEG_W'(deg_fix);
      default: ;
    endcase
  end

endmodule

@@ src/chc_back.sv @@
// back end: calibration state, cordic sequencing and the result register
module chc_back import chc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  item_t                   q_item,
  output logic                    q_pop,
  output logic                    cd_start,
  input  logic                    cd_done,
  input  logic [DEG_W-1:0]        cd_heading,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [DEG_W-1:0]        heading_deg,
  output logic signed [MAG_W-1:0] offset_x,
  output logic signed [MAG_W-1:0] offset_y,
  output logic signed [MAG_W-1:0] offset_z
);

  bk_state_t state;
  bk_state_t state_next;

  logic signed [MAG_W-1:0] axis_max    [3];
  logic signed [MAG_W-1:0] axis_min    [3];
  logic signed [MAG_W-1:0] axis_offset [3];
  logic signed [MAG_W-1:0] samp        [3];
  logic signed [MAG_W-1:0] off_new     [3];
  logic signed [MAG_W:0]   mid_sum     [3];
  logic signed [MAG_W:0]   mid_rnd     [3];

  logic out_free;
  logic cal_fire;
  logic load_cal;
  logic load_head;
  logic result_valid_next;

  assign samp[0]  = q_item.x;
  assign samp[1]  = q_item.y;
  assign samp[2]  = q_item.z;
  assign out_free = !result_valid || result_ready;
  assign cal_fire = load_cal;

  // midpoint of min and max, truncated toward zero
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mid_sum[k] = {axis_max[k][MAG_W-1], axis_max[k]} + {axis_min[k][MAG_W-1], axis_min[k]};
      mid_rnd[k] = (mid_sum[k] + (MAG_W+1)'(mid_sum[k][MAG_W])) >>> 1;
      case (q_item.op)
        OP_CAL_START: off_new[k] = '0;
        OP_CAL_END:   off_new[k] = mid_rnd[k][MAG_W-1:0];
        default:      off_new[k] = axis_offset[k];
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of queued words
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    cd_start   = 1'b0;
    load_cal   = 1'b0;
    load_head  = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_HEADING) begin
            q_pop      = 1'b1;
            cd_start   = 1'b1;
            state_next = BK_RUN;
          end else if (out_free) begin
            q_pop    = 1'b1;
            load_cal = 1'b1;
          end
        end
      end
      BK_RUN: begin
        if (cd_done) begin
          if (out_free) begin
            load_head  = 1'b1;
            state_next = BK_IDLE;
          end else begin
            state_next = BK_HOLD;
          end
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_head  = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        axis_max[k]    <= '0;
        axis_min[k]    <= '0;
        axis_offset[k] <= '0;
      end
    end else if (cal_fire) begin
      for (int k = 0; k < 3; k++) begin
        axis_offset[k] <= off_new[k];
        case (q_item.op)
          OP_CAL_START: begin
            axis_max[k] <= samp[k];
            axis_min[k] <= samp[k];
          end
          OP_CAL_SAMPLE: begin
            if (samp[k] > axis_max[k]) axis_max[k] <= samp[k];
            if (samp[k] < axis_min[k]) axis_min[k] <= samp[k];
          end
          default: ;
        endcase
      end
    end
  end

  // result word register
  assign result_valid_next = (load_cal || load_head) ? 1'b1 :
                             (result_ready ? 1'b0 : result_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cal) begin
      heading_deg <= '0;
      offset_x    <= off_new[0];
      offset_y    <= off_new[1];
      offset_z    <= off_new[2];
    end else if (load_head) begin
      heading_deg <= cd_heading;
      offset_x    <= axis_offset[0];
      offset_y    <= axis_offset[1];
      offset_z    <= axis_offset[2];
    end
  end

endmodule

@@ src/compass_heading_hard_iron_cal.sv @@
// top level of the compass heading and hard-iron calibration block
// Each sample word carries an action and a three-axis magnetometer reading and
// yields exactly one result word holding the heading (heading samples only,
// else 0) and the current per-axis hard-iron offsets. Calibration words
// (start, sample, end) are handled in the back end alone. A heading word
// runs through the iterative CORDIC, one rotation per cycle, on its way from
// the queue to its result; a word with a zero Y axis skips the rotations.
// A two-word queue in front of the back end keeps taking samples while the
// CORDIC runs, and the result register lets the next heading word start
// while a result waits to be taken. The heading is raw, not corrected by the
// offsets.
module compass_heading_hard_iron_cal import chc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  logic [1:0]              action,
  input  logic signed [MAG_W-1:0] mag_x,
  input  logic signed [MAG_W-1:0] mag_y,
  input  logic signed [MAG_W-1:0] mag_z,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [DEG_W-1:0]        heading_deg,
  output logic signed [MAG_W-1:0] offset_x,
  output logic signed [MAG_W-1:0] offset_y,
  output logic signed [MAG_W-1:0] offset_z
);

  logic             q_valid;
  item_t            q_item;
  logic             q_pop;
  logic             cd_start;
  logic             cd_done;
  logic [DEG_W-1:0] cd_heading;

  // decode and queue
  chc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .action       (action),
    .mag_x        (mag_x),
    .mag_y        (mag_y),
    .mag_z        (mag_z),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // angle unit
  chc_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cd_start),
    .mag_x   (q_item.x),
    .mag_y   (q_item.y),
    .done    (cd_done),
    .heading (cd_heading)
  );

  // execution and result
  chc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .cd_start     (cd_start),
    .cd_done      (cd_done),
    .cd_heading   (cd_heading),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .heading_deg  (heading_deg),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .offset_z     (offset_z)
  );

`ifndef SYNTHESIS
  // heading always wrapped into range
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> heading_deg < DEG_360)
    else $error("heading out of range");

  // back end only pops a queued word
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // cordic never finishes the cycle after it starts
  a_cordic_latency: assert property (@(posedge clk) disable iff (rst)
    cd_start |=> !cd_done)
    else $error("cordic done too early");
`endif

endmodule

@@ tb/compass_heading_hard_iron_cal_tb.sv @@
// self-checking testbench for the compass heading and hard-iron calibration block
module compass_heading_hard_iron_cal_tb;
  import chc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int ATAN_ENTRIES   = 24;

  // one result word as the block should report it
  typedef struct packed {
    logic [DEG_W-1:0]        heading;
    logic signed [MAG_W-1:0] off_x;
    logic signed [MAG_W-1:0] off_y;
    logic signed [MAG_W-1:0] off_z;
  } reading_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    sample_valid;
  logic                    sample_ready;
  logic [1:0]              action;
  logic signed [MAG_W-1:0] mag_x;
  logic signed [MAG_W-1:0] mag_y;
  logic signed [MAG_W-1:0] mag_z;
  logic                    result_valid;
  logic                    result_ready;
  logic [DEG_W-1:0]        heading_deg;
  logic signed [MAG_W-1:0] offset_x;
  logic signed [MAG_W-1:0] offset_y;
  logic signed [MAG_W-1:0] offset_z;

  // stimulus and expectation stores
  item_t    sample_backlog[$];
  reading_t owed_readings[$];

  // predictor copy of the calibration state
  int cal_max[3] = '{0, 0, 0};
  int cal_min[3] = '{0, 0, 0};
  int cal_off[3] = '{0, 0, 0};

  // arctangent of 2^-i in degrees, 16 fraction bits
  longint arctan_q16 [0:ATAN_ENTRIES-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // bookkeeping
  logic sample_taken;
  logic steady_tail;
  int   send_gap, ready_hold, phase_cnt, send_pct, stall_pct;
  int   stalled_cycles;
  int   fail_count, checked_count, heading_count, cal_close_count, cal_open_count;

  compass_heading_hard_iron_cal dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .action       (action),
    .mag_x        (mag_x),
    .mag_y        (mag_y),
    .mag_z        (mag_z),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .heading_deg  (heading_deg),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .offset_z     (offset_z)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // vectoring cordic on the raw x/y field, whole degrees 0..359
  function automatic logic [DEG_W-1:0] heading_of_field(input int fx, input int fy);
    longint vx, vy, ang, prev;
    int     i;
    if (fy == 0) return (fx < 0) ? DEG_W'(180) : DEG_W'(0);
    if (fy > 0) begin
      vx  = longint'(fy) <<< PRESCALE_SH;
      vy  = -(longint'(fx) <<< PRESCALE_SH);
      ang = 64'sd90 <<< DEG_FRAC;
    end else begin
      vx  = -(longint'(fy) <<< PRESCALE_SH);
      vy  = longint'(fx) <<< PRESCALE_SH;
      ang = -(64'sd90 <<< DEG_FRAC);
    end
    for (i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
      prev = vx;
      if (vy > 0) begin
        vx  = vx + (vy >>> i);
        vy  = vy - (prev >>> i);
        ang = ang + arctan_q16[i];
      end else if (vy < 0) begin
        vx  = vx - (vy >>> i);
        vy  = vy + (prev >>> i);
        ang = ang - arctan_q16[i];
      end
    end
    if (ang < 0) ang = ang + (64'sd360 <<< DEG_FRAC);
    if (ang < 0) ang = 0;
    ang = ang >>> DEG_FRAC;
    while (ang >= 360) ang = ang - 360;
    return ang[DEG_W-1:0];
  endfunction

  // update the calibration state for one word and build its reading
  function automatic reading_t apply_sample(input item_t w);
    reading_t r;
    int       s[3];
    s[0] = w.x;
    s[1] = w.y;
    s[2] = w.z;
    r.heading = '0;
    case (w.op)
      OP_HEADING: r.heading = heading_of_field(s[0], s[1]);
      OP_CAL_START: begin
        for (int k = 0; k < 3; k++) begin
          cal_off[k] = 0;
          cal_max[k] = s[k];
          cal_min[k] = s[k];
        end
      end
      OP_CAL_SAMPLE: begin
        for (int k = 0; k < 3; k++) begin
          if (s[k] > cal_max[k]) cal_max[k] = s[k];
          if (s[k] < cal_min[k]) cal_min[k] = s[k];
        end
      end
      default: begin
        // midpoint, truncated toward zero
        for (int k = 0; k < 3; k++) cal_off[k] = (cal_max[k] + cal_min[k]) / 2;
      end
    endcase
    r.off_x = MAG_W'(cal_off[0]);
    r.off_y = MAG_W'(cal_off[1]);
    r.off_z = MAG_W'(cal_off[2]);
    return r;
  endfunction

  // axis value biased toward the extremes and toward small magnitudes
  function automatic int draw_axis();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return -32768;
          1:       return 32767;
          2:       return 0;
          3:       return -1;
          default: return 1;
        endcase
      end
      1, 2:    return int'($urandom_range(0, 16)) - 8;
      default: return int'(shortint'($urandom));
    endcase
  endfunction

  task automatic add_word(input op_t op, input int x, input int y, input int z);
    item_t w;
    w.op = op;
    w.x  = MAG_W'(x);
    w.y  = MAG_W'(y);
    w.z  = MAG_W'(z);
    sample_backlog.push_back(w);
  endtask

  task automatic add_heading();
    if ($urandom_range(0, 9) == 0) add_word(OP_HEADING, draw_axis(), 0, draw_axis());
    else add_word(OP_HEADING, draw_axis(), draw_axis(), draw_axis());
  endtask

  // mostly whole calibration sessions followed by headings, some stray words
  task automatic queue_random(input int count);
    int left, n;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        add_word(op_t'($urandom_range(0, 3)), draw_axis(), draw_axis(), draw_axis());
        left--;
      end else begin
        n = $urandom_range(1, 8);
        add_word(OP_CAL_START, draw_axis(), draw_axis(), draw_axis());
        repeat (n) add_word(OP_CAL_SAMPLE, draw_axis(), draw_axis(), draw_axis());
        // now and then a session is left open
        if ($urandom_range(0, 7) != 0) begin
          add_word(OP_CAL_END, draw_axis(), draw_axis(), draw_axis());
          left--;
        end
        left -= n + 1;
        n = $urandom_range(2, 12);
        repeat (n) add_heading();
        left -= n;
      end
    end
  endtask

  // wait until every queued word went in and every reading came back
  task automatic wait_drained();
    do @(posedge clk);
    while (sample_backlog.size() != 0 || sample_valid || owed_readings.size() != 0);
  endtask

  // sender: new word at the falling edge, held until taken
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap     <= 0;
    end else if (!sample_valid || sample_taken) begin
      if (send_gap != 0) begin
        sample_valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (sample_backlog.size() == 0) begin
        sample_valid <= 1'b0;
      end else if (!steady_tail && $urandom_range(0, 99) < send_pct) begin
        sample_valid <= 1'b0;
        send_gap     <= $urandom_range(0, 4);
      end else begin
        item_t w;
        w = sample_backlog.pop_front();
        action       <= w.op;
        mag_x        <= w.x;
        mag_y        <= w.y;
        mag_z        <= w.z;
        sample_valid <= 1'b1;
      end
    end
  end

  // receiver: stall bursts; the idling rates of both sides are redrawn each time the phase counter wraps
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      ready_hold   <= 0;
      phase_cnt    <= 0;
      send_pct     <= 0;
      stall_pct    <= 0;
    end else begin
      phase_cnt <= (phase_cnt == 49) ? 0 : phase_cnt + 1;
      if (phase_cnt == 0) begin
        case ($urandom_range(0, 3))
          0:       send_pct <= 0;
          1:       send_pct <= 10;
          2:       send_pct <= 30;
          default: send_pct <= 60;
        endcase
        case ($urandom_range(0, 3))
          0:       stall_pct <= 0;
          1:       stall_pct <= 10;
          2:       stall_pct <= 30;
          default: stall_pct <= 60;
        endcase
      end
      if (ready_hold != 0) begin
        result_ready <= 1'b0;
        ready_hold   <= ready_hold - 1;
      end else if (!steady_tail && $urandom_range(0, 99) < stall_pct) begin
        result_ready <= 1'b0;
        ready_hold   <= $urandom_range(0, 4);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each accepted word, check each accepted result
  always @(posedge clk) begin
    if (rst) begin
      sample_taken   <= 1'b0;
      stalled_cycles <= 0;
      for (int k = 0; k < 3; k++) begin
        cal_max[k] = 0;
        cal_min[k] = 0;
        cal_off[k] = 0;
      end
    end else begin
      sample_taken <= sample_valid && sample_ready;
      if (sample_valid && sample_ready) begin
        item_t w;
        w.op = op_t'(action);
        w.x  = mag_x;
        w.y  = mag_y;
        w.z  = mag_z;
        owed_readings.push_back(apply_sample(w));
        case (w.op)
          OP_HEADING:   heading_count++;
          OP_CAL_START: cal_open_count++;
          OP_CAL_END:   cal_close_count++;
          default:      ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (owed_readings.size() == 0) begin
          $error("result word with no reading owed: heading_deg %0d", heading_deg);
          fail_count++;
        end else begin
          reading_t exp_r;
          exp_r = owed_readings.pop_front();
          checked_count++;
          if (heading_deg !== exp_r.heading) begin
            $error("heading_deg: expected %0d, got %0d", exp_r.heading, heading_deg);
            fail_count++;
          end
          if (offset_x !== exp_r.off_x) begin
            $error("offset_x: expected %0d, got %0d", exp_r.off_x, offset_x);
            fail_count++;
          end
          if (offset_y !== exp_r.off_y) begin
            $error("offset_y: expected %0d, got %0d", exp_r.off_y, offset_y);
            fail_count++;
          end
          if (offset_z !== exp_r.off_z) begin
            $error("offset_z: expected %0d, got %0d", exp_r.off_z, offset_z);
            fail_count++;
          end
        end
      end
      // watchdog on handshake activity
      if ((sample_valid && sample_ready) || (result_valid && result_ready)) begin
        stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("compass_heading_hard_iron_cal: mismatch");
        $finish;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  // reset, stimulus and end of run
  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    result_ready = 1'b0;
    action       = OP_HEADING;
    mag_x        = '0;
    mag_y        = '0;
    mag_z        = '0;
    steady_tail  = 1'b0;
    fail_count   = 0;
    checked_count   = 0;
    heading_count   = 0;
    cal_close_count = 0;
    cal_open_count  = 0;

    // directed: axis directions, extremes, zero vector
    add_word(OP_HEADING, 0, 0, 0);
    add_word(OP_HEADING, 100, 0, 0);
    add_word(OP_HEADING, -100, 0, 0);
    add_word(OP_HEADING, 0, 100, 0);
    add_word(OP_HEADING, 0, -100, 0);
    add_word(OP_HEADING, 32767, 32767, 32767);
    add_word(OP_HEADING, -32768, -32768, -32768);
    add_word(OP_HEADING, -32768, 32767, 0);
    add_word(OP_HEADING, 32767, -32768, -1);
    add_word(OP_HEADING, -1, 1, 0);
    add_word(OP_HEADING, 1, -1, 0);
    // end and sample with no start, end ignores its own sample
    add_word(OP_CAL_END, 5, 5, 5);
    add_word(OP_CAL_SAMPLE, -32768, 32767, -1);
    add_word(OP_CAL_END, 0, 0, 0);
    // full-scale session, odd sums truncate toward zero
    add_word(OP_CAL_START, 32767, -32768, -1);
    add_word(OP_CAL_SAMPLE, -32768, 32767, -2);
    add_word(OP_CAL_SAMPLE, 0, 0, 0);
    add_word(OP_CAL_END, 0, 0, 0);
    add_word(OP_HEADING, -5, -5, 0);
    // session with a start word only
    add_word(OP_CAL_START, -3, 7, -32768);
    add_word(OP_CAL_END, 32767, 32767, 32767);
    add_word(OP_HEADING, -32768, 0, 0);
    add_word(OP_HEADING, 0, -32768, 0);

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // random words are queued only once the directed part is fully answered
    wait_drained();
    queue_random(390);
    wait_drained();
    steady_tail = 1'b1;
    queue_random(60);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (owed_readings.size() != 0) begin
      $error("%0d readings never returned", owed_readings.size());
      fail_count++;
    end
    $display("checked %0d result words: %0d heading samples, %0d calibration starts,",
             checked_count, heading_count, cal_open_count);
    $display("%0d calibration ends, with random idling on both sides and a steady tail",
             cal_close_count);
    if (fail_count == 0) begin
      $display("compass_heading_hard_iron_cal: match");
    end else begin
      $display("compass_heading_hard_iron_cal: mismatch");
    end
    $finish;
  end

endmodule
